@@ src/shc_pkg.sv @@
// -----------------------------------------------------------------------------
// shc_pkg: shared types and constants for the static Huffman codec
// Command and status codes, queue entry and result layouts, sizes.
// -----------------------------------------------------------------------------
package shc_pkg;

  localparam int unsigned ALPHA_SIZE = 256;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned NODE_W     = 9;
  localparam int unsigned NODE_CNT   = 2 * ALPHA_SIZE - 1;
  localparam int unsigned INNER_CNT  = ALPHA_SIZE - 1;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned WGT_W      = CNT_W + 1;
  localparam int unsigned CODE_W     = 32;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned DEPTH_W    = 9;
  localparam int unsigned LEN_LIMIT  = 32;
  localparam int unsigned DIST_W     = 9;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned STAT_W     = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_COUNT  = 3'd1,
    CMD_BUILD  = 3'd2,
    CMD_ENCODE = 3'd3,
    CMD_DECODE = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_BUILT = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [SYM_W-1:0] symbol;
    logic             code_bit;
  } cmd_entry_t;

  typedef struct packed {
    logic       valid;
    cmd_entry_t entry;
  } queue_head_t;

  typedef struct packed {
    status_e           status;
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
    logic [SYM_W-1:0]  decoded_symbol;
    logic [DIST_W-1:0] distinct_symbols;
  } result_t;

endpackage

@@ src/shc_front.sv @@
// -----------------------------------------------------------------------------
// shc_front: request intake and command classification
// Accept requests while the queue has room; drop unknown command codes.
// -----------------------------------------------------------------------------
module shc_front import shc_pkg::*; (
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [CMD_W-1:0] cmd_raw_i,
  input  logic [SYM_W-1:0] symbol_i,
  input  logic             code_bit_i,
  input  logic             full_i,
  output logic             push_o,
  output cmd_entry_t       entry_o
);

  logic known;
  cmd_e cmd;

  always_comb begin
    known = 1'b1;
    cmd   = CMD_CLEAR;
    unique case (cmd_raw_i)
      CMD_CLEAR:  cmd = CMD_CLEAR;
      CMD_COUNT:  cmd = CMD_COUNT;
      CMD_BUILD:  cmd = CMD_BUILD;
      CMD_ENCODE: cmd = CMD_ENCODE;
      CMD_DECODE: cmd = CMD_DECODE;
      default:    known = 1'b0;
    endcase
  end

  assign s_tready_o       = !full_i;
  assign push_o           = s_tvalid_i && !full_i && known;
  assign entry_o.cmd      = cmd;
  assign entry_o.symbol   = symbol_i;
  assign entry_o.code_bit = code_bit_i;

endmodule

@@ src/shc_fifo.sv @@
// -----------------------------------------------------------------------------
// shc_fifo: command queue between intake and execution
// Small circular buffer of classified requests.
// -----------------------------------------------------------------------------
module shc_fifo import shc_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  cmd_entry_t  entry_i,
  output logic        full_o,
  input  logic        pop_i,
  output queue_head_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);

  cmd_entry_t           mem_q [DEPTH];
  logic [PTR_W-1:0]     wptr_q, rptr_q;
  logic [CNT_W_Q-1:0]   cnt_q;

  assign full_o       = (cnt_q == CNT_W_Q'(DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W_Q'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W_Q'(1);
      end
    end
  end

endmodule

@@ src/shc_back.sv @@
// -----------------------------------------------------------------------------
// shc_back: command execution engine
// Histogram, tree build, code table, encode and decode walk, result register.
// -----------------------------------------------------------------------------
module shc_back import shc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  queue_head_t head_i,
  output logic        pop_o,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output result_t     result_o
);

  localparam int unsigned DB_W = DEPTH_W + CODE_W;
  localparam int unsigned CH_W = 2 * NODE_W;
  localparam int unsigned K_W  = $clog2(INNER_CNT);
  localparam int unsigned WE_W = WGT_W + 1;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_CNT      = 15'b000000000000010,
    S_ENC      = 15'b000000000000100,
    S_DEC      = 15'b000000000001000,
    S_INIT     = 15'b000000000010000,
    S_INIT_END = 15'b000000000100000,
    S_MRG      = 15'b000000001000000,
    S_MRG_WR   = 15'b000000010000000,
    S_KILL_A   = 15'b000000100000000,
    S_KILL_B   = 15'b000001000000000,
    S_TRV_INIT = 15'b000010000000000,
    S_TRV_RD   = 15'b000100000000000,
    S_TRV_W0   = 15'b001000000000000,
    S_TRV_W1   = 15'b010000000000000,
    S_TRV_END  = 15'b100000000000000
  } state_e;

  // storage; a weight entry carries a live flag above the weight
  logic [CNT_W-1:0] hist_mem [ALPHA_SIZE];
  logic [WE_W-1:0]  wgt_mem  [NODE_CNT];
  logic [CH_W-1:0]  ch_mem   [INNER_CNT];
  logic [DB_W-1:0]  db_mem   [NODE_CNT];

  logic             h_we, h_re, w_we, w_re, c_we, c_re, d_we, d_re;
  logic [SYM_W-1:0] h_ra, h_wa;
  logic [CNT_W-1:0] h_wd, h_rd_q;
  logic             hvld_rd_q;
  logic [NODE_W-1:0] w_ra, w_wa;
  logic [WE_W-1:0]  w_wd, w_rd_q;
  logic [K_W-1:0]   c_ra, c_wa;
  logic [CH_W-1:0]  c_wd, c_rd_q;
  logic [NODE_W-1:0] d_ra, d_wa;
  logic [DB_W-1:0]  d_wd, d_rd_q;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [ALPHA_SIZE-1:0] hist_vld_q, hist_vld_d, coded_q, coded_d;
  logic              built_q, built_d, err_q, err_d;
  logic [NODE_W-1:0] root_q, root_d, walk_q, walk_d, a_q, a_d, n_q, n_d;
  logic [NODE_W-1:0] p_idx_q, p_idx_d;
  logic              p_vld_q, p_vld_d;
  logic [K_W-1:0]    k_q, k_d;
  logic [SYM_W-1:0]  sym_q, sym_d, last_q, last_d;
  logic              bit_q, bit_d;
  logic              m1v_q, m1v_d, m2v_q, m2v_d;
  logic [WGT_W-1:0]  m1w_q, m1w_d, m2w_q, m2w_d;
  logic [NODE_W-1:0] m1i_q, m1i_d, m2i_q, m2i_d;
  logic              out_vld_q;
  result_t           out_q, res;
  logic              res_en, out_free;

  logic [CNT_W-1:0]   hv;
  logic [NODE_W-1:0]  top, nxt, child;
  logic [DEPTH_W-1:0] cdepth;
  logic [CODE_W-1:0]  cbits;
  logic               bsel;
  logic               w_rd_live;
  logic [WGT_W-1:0]   w_rd_wgt;

  assign out_free   = !out_vld_q || m_tready_i;
  assign m_tvalid_o = out_vld_q;
  assign result_o   = out_q;

  assign hv        = hvld_rd_q ? h_rd_q : '0;
  assign top       = {1'b1, k_q};
  assign nxt       = bit_q ? c_rd_q[NODE_W +: NODE_W] : c_rd_q[NODE_W-1:0];
  assign bsel      = (state_q == S_TRV_W1);
  assign child     = bsel ? c_rd_q[NODE_W +: NODE_W] : c_rd_q[NODE_W-1:0];
  assign cdepth    = d_rd_q[CODE_W +: DEPTH_W] + DEPTH_W'(1);
  assign cbits     = {d_rd_q[CODE_W-2:0], bsel};
  assign w_rd_live = w_rd_q[WGT_W];
  assign w_rd_wgt  = w_rd_q[WGT_W-1:0];

  always_comb begin
    state_d    = state_q;
    total_d    = total_q;
    hist_vld_d = hist_vld_q;
    coded_d    = coded_q;
    built_d    = built_q;
    err_d      = err_q;
    root_d     = root_q;
    walk_d     = walk_q;
    a_d        = a_q;
    n_d        = n_q;
    p_idx_d    = p_idx_q;
    p_vld_d    = p_vld_q;
    k_d        = k_q;
    sym_d      = sym_q;
    bit_d      = bit_q;
    last_d     = last_q;
    m1v_d = m1v_q; m1w_d = m1w_q; m1i_d = m1i_q;
    m2v_d = m2v_q; m2w_d = m2w_q; m2i_d = m2i_q;
    h_we = 1'b0; h_re = 1'b0; h_ra = '0; h_wa = '0; h_wd = '0;
    w_we = 1'b0; w_re = 1'b0; w_ra = '0; w_wa = '0; w_wd = '0;
    c_we = 1'b0; c_re = 1'b0; c_ra = '0; c_wa = '0; c_wd = '0;
    d_we = 1'b0; d_re = 1'b0; d_ra = '0; d_wa = '0; d_wd = '0;
    pop_o  = 1'b0;
    res_en = 1'b0;
    res    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid && out_free) begin
          pop_o = 1'b1;
          sym_d = head_i.entry.symbol;
          bit_d = head_i.entry.code_bit;
          unique case (head_i.entry.cmd)
            CMD_CLEAR: begin
              hist_vld_d = '0;
              total_d    = '0;
              coded_d    = '0;
              built_d    = 1'b0;
              root_d     = '0;
              walk_d     = '0;
              res_en     = 1'b1;
            end
            CMD_COUNT: begin
              h_re    = 1'b1;
              h_ra    = head_i.entry.symbol;
              state_d = S_CNT;
            end
            CMD_BUILD: begin
              coded_d = '0;
              built_d = 1'b0;
              root_d  = '0;
              walk_d  = '0;
              a_d     = '0;
              p_vld_d = 1'b0;
              n_d     = '0;
              err_d   = 1'b0;
              state_d = S_INIT;
            end
            CMD_ENCODE: begin
              if (!built_q || !coded_q[head_i.entry.symbol]) begin
                res_en     = 1'b1;
                res.status = ST_NOT_BUILT;
              end else begin
                d_re    = 1'b1;
                d_ra    = {1'b0, head_i.entry.symbol};
                state_d = S_ENC;
              end
            end
            CMD_DECODE: begin
              if (!built_q) begin
                res_en     = 1'b1;
                res.status = ST_NOT_BUILT;
              end else if (root_q < NODE_W'(ALPHA_SIZE)) begin
                res_en             = 1'b1;
                res.decoded_symbol = root_q[SYM_W-1:0];
              end else begin
                c_re    = 1'b1;
                c_ra    = walk_q[K_W-1:0];
                state_d = S_DEC;
              end
            end
            default: ;
          endcase
        end
      end

      S_CNT: begin
        res_en = 1'b1;
        if (hv == CNT_MAX || total_q == CNT_MAX) begin
          res.status = ST_OVERFLOW;
        end else begin
          h_we              = 1'b1;
          h_wa              = sym_q;
          h_wd              = hv + CNT_W'(1);
          hist_vld_d[sym_q] = 1'b1;
          total_d           = total_q + CNT_W'(1);
        end
        state_d = S_IDLE;
      end

      S_ENC: begin
        res_en          = 1'b1;
        res.code_word   = d_rd_q[CODE_W-1:0];
        res.code_length = d_rd_q[CODE_W +: LEN_W];
        state_d         = S_IDLE;
      end

      S_DEC: begin
        if (nxt < NODE_W'(ALPHA_SIZE)) begin
          res_en             = 1'b1;
          res.decoded_symbol = nxt[SYM_W-1:0];
          walk_d             = root_q;
        end else begin
          walk_d = nxt;
        end
        state_d = S_IDLE;
      end

      // load leaf weights from the histogram, mark live leaves
      S_INIT: begin
        if (a_q < NODE_W'(ALPHA_SIZE)) begin
          h_re    = 1'b1;
          h_ra    = a_q[SYM_W-1:0];
          a_d     = a_q + NODE_W'(1);
          p_vld_d = 1'b1;
          p_idx_d = a_q;
        end else begin
          p_vld_d = 1'b0;
        end
        if (p_vld_q) begin
          w_we = 1'b1;
          w_wa = p_idx_q;
          w_wd = {hv != '0, 1'b0, hv};
          if (hv != '0) begin
            n_d    = n_q + NODE_W'(1);
            last_d = p_idx_q[SYM_W-1:0];
          end
        end
        if (a_q == NODE_W'(ALPHA_SIZE) && !p_vld_q) begin
          state_d = S_INIT_END;
        end
      end

      S_INIT_END: begin
        res.distinct_symbols = n_q;
        if (n_q == '0) begin
          res_en     = 1'b1;
          res.status = ST_EMPTY;
          state_d    = S_IDLE;
        end else if (n_q == NODE_W'(1)) begin
          res_en          = 1'b1;
          root_d          = {1'b0, last_q};
          walk_d          = {1'b0, last_q};
          built_d         = 1'b1;
          coded_d[last_q] = 1'b1;
          d_we            = 1'b1;
          d_wa            = {1'b0, last_q};
          d_wd            = {DEPTH_W'(1), CODE_W'(0)};
          state_d         = S_IDLE;
        end else begin
          k_d     = '0;
          a_d     = '0;
          p_vld_d = 1'b0;
          m1v_d   = 1'b0;
          m2v_d   = 1'b0;
          state_d = S_MRG;
        end
      end

      // scan nodes below top, keep the two least (weight, index)
      S_MRG: begin
        if (a_q < top) begin
          w_re    = 1'b1;
          w_ra    = a_q;
          a_d     = a_q + NODE_W'(1);
          p_vld_d = 1'b1;
          p_idx_d = a_q;
        end else begin
          p_vld_d = 1'b0;
        end
        if (p_vld_q && w_rd_live) begin
          if (!m1v_q || w_rd_wgt < m1w_q) begin
            m2v_d = m1v_q; m2w_d = m1w_q;    m2i_d = m1i_q;
            m1v_d = 1'b1;  m1w_d = w_rd_wgt; m1i_d = p_idx_q;
          end else if (!m2v_q || w_rd_wgt < m2w_q) begin
            m2v_d = 1'b1;  m2w_d = w_rd_wgt; m2i_d = p_idx_q;
          end
        end
        if (a_q == top && !p_vld_q) begin
          state_d = S_MRG_WR;
        end
      end

      S_MRG_WR: begin
        w_we    = 1'b1;
        w_wa    = top;
        w_wd    = {1'b1, m1w_q + m2w_q};
        c_we    = 1'b1;
        c_wa    = k_q;
        c_wd    = {m2i_q, m1i_q};
        state_d = S_KILL_A;
      end

      // retire both merged children from later scans
      S_KILL_A: begin
        w_we    = 1'b1;
        w_wa    = m1i_q;
        w_wd    = '0;
        state_d = S_KILL_B;
      end

      S_KILL_B: begin
        w_we = 1'b1;
        w_wa = m2i_q;
        w_wd = '0;
        if (NODE_W'(k_q) == n_q - NODE_W'(2)) begin
          root_d  = top;
          state_d = S_TRV_INIT;
        end else begin
          k_d     = k_q + K_W'(1);
          a_d     = '0;
          m1v_d   = 1'b0;
          m2v_d   = 1'b0;
          state_d = S_MRG;
        end
      end

      // walk merged nodes from the root down, assign depth and code bits
      S_TRV_INIT: begin
        d_we    = 1'b1;
        d_wa    = root_q;
        d_wd    = '0;
        state_d = S_TRV_RD;
      end

      S_TRV_RD: begin
        c_re    = 1'b1;
        c_ra    = k_q;
        d_re    = 1'b1;
        d_ra    = {1'b1, k_q};
        state_d = S_TRV_W0;
      end

      S_TRV_W0, S_TRV_W1: begin
        d_we = 1'b1;
        d_wa = child;
        d_wd = {cdepth, cbits};
        if (child < NODE_W'(ALPHA_SIZE)) begin
          coded_d[child[SYM_W-1:0]] = 1'b1;
          if (cdepth > DEPTH_W'(LEN_LIMIT)) begin
            err_d = 1'b1;
          end
        end
        if (state_q == S_TRV_W0) begin
          state_d = S_TRV_W1;
        end else if (k_q == '0) begin
          state_d = S_TRV_END;
        end else begin
          k_d     = k_q - K_W'(1);
          state_d = S_TRV_RD;
        end
      end

      S_TRV_END: begin
        res_en               = 1'b1;
        res.distinct_symbols = n_q;
        if (err_q) begin
          res.status = ST_OVERFLOW;
          coded_d    = '0;
          root_d     = '0;
          walk_d     = '0;
        end else begin
          walk_d  = root_q;
          built_d = 1'b1;
        end
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hist_mem[h_wa] <= h_wd;
    end
    if (h_re) begin
      h_rd_q    <= hist_mem[h_ra];
      hvld_rd_q <= hist_vld_q[h_ra];
    end
    if (w_we) begin
      wgt_mem[w_wa] <= w_wd;
    end
    if (w_re) begin
      w_rd_q <= wgt_mem[w_ra];
    end
    if (c_we) begin
      ch_mem[c_wa] <= c_wd;
    end
    if (c_re) begin
      c_rd_q <= ch_mem[c_ra];
    end
    if (d_we) begin
      db_mem[d_wa] <= d_wd;
    end
    if (d_re) begin
      d_rd_q <= db_mem[d_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q   <= sym_d;
    bit_q   <= bit_d;
    p_idx_q <= p_idx_d;
    last_q  <= last_d;
    m1w_q   <= m1w_d;
    m1i_q   <= m1i_d;
    m2w_q   <= m2w_d;
    m2i_q   <= m2i_d;
    if (res_en) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      total_q    <= '0;
      hist_vld_q <= '0;
      coded_q    <= '0;
      built_q    <= 1'b0;
      err_q      <= 1'b0;
      root_q     <= '0;
      walk_q     <= '0;
      a_q        <= '0;
      n_q        <= '0;
      p_vld_q    <= 1'b0;
      k_q        <= '0;
      m1v_q      <= 1'b0;
      m2v_q      <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      total_q    <= total_d;
      hist_vld_q <= hist_vld_d;
      coded_q    <= coded_d;
      built_q    <= built_d;
      err_q      <= err_d;
      root_q     <= root_d;
      walk_q     <= walk_d;
      a_q        <= a_d;
      n_q        <= n_d;
      p_vld_q    <= p_vld_d;
      k_q        <= k_d;
      m1v_q      <= m1v_d;
      m2v_q      <= m2v_d;
      if (res_en) begin
        out_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

endmodule

@@ src/static_huffman_codec.sv @@
// -----------------------------------------------------------------------------
// static_huffman_codec: two-pass byte Huffman codec
// Clear passes through the queue and the result register; count, encode and
// decode pass through the queue, one registered memory read and the result
// register. The single execution engine takes one request at a time, and no
// new one before the last is through. Build, for n distinct bytes: leaf load,
// then a linear minimum scan over the node weights for each of the n-1 merges.
// Reset clears all control state at once; no clearing pass is needed.
// -----------------------------------------------------------------------------
module static_huffman_codec import shc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] symbol, [8] code_bit, rest zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [31:0] code_word, [37:32] code_length,
                                      // [45:38] decoded_symbol,
                                      // [54:46] distinct_symbols, [55] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic        full, push, pop;
  cmd_entry_t  entry;
  queue_head_t head;
  result_t     result;

  // Front: classify each request and drop unknown command codes.
  shc_front u_front (
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .cmd_raw_i  (s_axis_tuser),
    .symbol_i   (s_axis_tdata[SYM_W-1:0]),
    .code_bit_i (s_axis_tdata[SYM_W]),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (entry)
  );

  // Queue: decouple intake from the long-running build.
  shc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head)
  );

  // Back: execute one command at a time, hold its result until taken.
  shc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .result_o   (result)
  );

  // Pack result fields, lowest first.
  assign m_axis_tuser = result.status;
  assign m_axis_tdata = {1'b0, result.distinct_symbols, result.decoded_symbol,
                         result.code_length, result.code_word};

endmodule

@@ src/shc_checker.sv @@
// -----------------------------------------------------------------------------
// shc_checker: port-level checks for the static Huffman codec
// Result channel stability and field consistency.
// -----------------------------------------------------------------------------
module shc_checker import shc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_len_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[37:32] != 6'd0 |-> m_axis_tuser == ST_OK)
    else $error("code length given with error status");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_EMPTY |-> m_axis_tdata[54:46] == 9'd0)
    else $error("empty histogram reported with symbols");

  a_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[54:46] <= 9'd256)
    else $error("distinct count beyond alphabet");

endmodule

bind static_huffman_codec shc_checker u_shc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ dv/tb_static_huffman_codec.sv @@
// -----------------------------------------------------------------------------
// tb_static_huffman_codec: self-checking testbench for the Huffman codec
// Drives clear, count, build, encode and decode requests on the input stream,
// predicts each result with its own histogram, tree and code table, and checks
// every result field in order. Random gaps on both sides, one long output hold.
// -----------------------------------------------------------------------------
module tb_static_huffman_codec;
  import shc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Codec behavior held in software: histogram, tree, code table, walk state.
  class huff_scoreboard;
    int unsigned hist [ALPHA_SIZE];
    int unsigned total;
    int unsigned weight [NODE_CNT];
    int unsigned kids [INNER_CNT][2];
    bit          live [NODE_CNT];
    int unsigned depth [NODE_CNT];
    bit [63:0]   bits [NODE_CNT];
    bit [31:0]   code_word [ALPHA_SIZE];
    int unsigned code_len [ALPHA_SIZE];
    int unsigned root;
    int unsigned walk;
    bit          built;
    result_t     expected_q [$];
    int          errors;

    function new();
      foreach (hist[i]) hist[i] = 0;
      total = 0;
      errors = 0;
      drop_table();
    endfunction

    function void drop_table();
      foreach (code_word[i]) begin
        code_word[i] = '0;
        code_len[i]  = 0;
      end
      built = 1'b0;
      root  = 0;
      walk  = 0;
    endfunction

    // Lowest weight among live nodes below lim; lower index wins a tie.
    function int lightest_node(int unsigned lim);
      int best;
      best = -1;
      for (int i = 0; i < lim; i++)
        if (live[i] && (best < 0 || weight[i] < weight[best])) best = i;
      return best;
    endfunction

    function status_e build_tree(output int unsigned distinct);
      int unsigned n, top, p, c;
      int a, b;
      n = 0;
      drop_table();
      foreach (live[i]) live[i] = 1'b0;
      for (int i = 0; i < ALPHA_SIZE; i++) begin
        weight[i] = hist[i];
        if (hist[i] != 0) begin
          live[i] = 1'b1;
          n++;
        end
      end
      distinct = n;
      if (n == 0) return ST_EMPTY;
      if (n == 1) begin
        for (int i = 0; i < ALPHA_SIZE; i++)
          if (live[i]) begin
            root = i;
            code_len[i] = 1;
          end
        walk  = root;
        built = 1'b1;
        return ST_OK;
      end
      for (int k = 0; k + 1 < n; k++) begin
        top = ALPHA_SIZE + k;
        a = lightest_node(top);
        live[a] = 1'b0;
        b = lightest_node(top);
        live[b] = 1'b0;
        weight[top] = weight[a] + weight[b];
        kids[k][0] = a;
        kids[k][1] = b;
        live[top] = 1'b1;
      end
      root = ALPHA_SIZE + n - 2;
      depth[root] = 0;
      bits[root]  = '0;
      for (int k = n - 2; k >= 0; k--) begin
        p = ALPHA_SIZE + k;
        for (int j = 0; j < 2; j++) begin
          c = kids[k][j];
          depth[c] = depth[p] + 1;
          bits[c]  = {bits[p][62:0], j[0]};
        end
      end
      for (int i = 0; i < ALPHA_SIZE; i++)
        if (hist[i] != 0 && depth[i] > LEN_LIMIT) begin
          drop_table();
          return ST_OVERFLOW;
        end
      for (int i = 0; i < ALPHA_SIZE; i++)
        if (hist[i] != 0) begin
          code_word[i] = bits[i][31:0];
          code_len[i]  = depth[i];
        end
      walk  = root;
      built = 1'b1;
      return ST_OK;
    endfunction

    // Note an accepted request and queue the result it causes, if any.
    function void note_request(logic [2:0] cmd, logic [7:0] sym, logic cbit);
      result_t     r;
      int unsigned n_dist, k, nxt;
      r = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_CLEAR: begin
          foreach (hist[i]) hist[i] = 0;
          total = 0;
          drop_table();
        end
        CMD_COUNT: begin
          if (hist[sym] >= CNT_MAX || total >= CNT_MAX) r.status = ST_OVERFLOW;
          else begin
            hist[sym]++;
            total++;
          end
        end
        CMD_BUILD: begin
          r.status = build_tree(n_dist);
          r.distinct_symbols = DIST_W'(n_dist);
        end
        CMD_ENCODE: begin
          if (!built || code_len[sym] == 0) r.status = ST_NOT_BUILT;
          else begin
            r.code_word   = code_word[sym];
            r.code_length = LEN_W'(code_len[sym]);
          end
        end
        CMD_DECODE: begin
          if (!built) r.status = ST_NOT_BUILT;
          else if (root < ALPHA_SIZE) r.decoded_symbol = SYM_W'(root);
          else begin
            k = walk - ALPHA_SIZE;
            if (walk < ALPHA_SIZE || k >= INNER_CNT) k = root - ALPHA_SIZE;
            nxt = kids[k][cbit];
            if (nxt < ALPHA_SIZE) begin
              r.decoded_symbol = SYM_W'(nxt);
              walk = root;
            end else begin
              walk = nxt;
              return;
            end
          end
        end
        default: return;
      endcase
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string field, longint unsigned got, longint unsigned want);
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got,
               want);
      errors++;
    endtask

    task check_result(logic [1:0] st, logic [55:0] d);
      result_t e;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", d, 0);
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.status) report_mismatch("status", st, e.status);
      if (d[31:0] !== e.code_word) report_mismatch("code_word", d[31:0], e.code_word);
      if (d[37:32] !== e.code_length)
        report_mismatch("code_length", d[37:32], e.code_length);
      if (d[45:38] !== e.decoded_symbol)
        report_mismatch("decoded_symbol", d[45:38], e.decoded_symbol);
      if (d[54:46] !== e.distinct_symbols)
        report_mismatch("distinct_symbols", d[54:46], e.distinct_symbols);
    endtask
  endclass

  localparam int unsigned IDLE_LIMIT = 500000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [7:0] symbol, [8] code_bit, rest zero
  logic [2:0]  s_axis_tuser;   // [2:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;   // [31:0] code_word, [37:32] code_length,
                               // [45:38] decoded_symbol, [54:46] distinct_symbols
  logic [1:0]  m_axis_tuser;   // [1:0] status

  huff_scoreboard sb;
  int unsigned    req_sent;
  int unsigned    res_seen;
  int unsigned    idle_cycles;
  bit             quiet;        // no gaps on either side in the closing stretch
  bit             held_once;

  static_huffman_codec dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Offer one request at the falling edge, hold it until the codec takes it.
  task send_req(logic [2:0] cmd, logic [7:0] sym, logic cbit);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {7'b0, cbit, sym};
    s_axis_tuser  = cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(cmd, sym, cbit);
    req_sent++;
    @(negedge clk_i);
  endtask

  // Feed the code of a symbol bit by bit, first bit first.
  task send_code(logic [7:0] sym);
    for (int i = int'(sb.code_len[sym]) - 1; i >= 0; i--)
      send_req(CMD_DECODE, 8'($urandom), sb.code_word[sym][i]);
  endtask

  // Sample results at the rising edge; the codec updates its outputs after it.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tuser, m_axis_tdata);
      res_seen++;
    end
  end

  // Receiver: random short holds, and one long hold to back up the codec.
  always begin
    @(negedge clk_i);
    if (!held_once && res_seen >= 100) begin
      held_once = 1'b1;
      m_axis_tready = 1'b0;
      repeat (300) @(negedge clk_i);
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      m_axis_tready = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    m_axis_tready = 1'b1;
  end

  // Watchdog: a long full build is the longest stretch without a handshake.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [7:0]  alph [$];
    logic [7:0]  s;
    int unsigned k, grp;

    sb            = new();
    req_sent      = 0;
    res_seen      = 0;
    idle_cycles   = 0;
    quiet         = 1'b0;
    held_once     = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_CLEAR;
    m_axis_tready = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: unbuilt table, empty histogram, unknown codes, lone symbol.
    send_req(CMD_ENCODE, 8'h00, 1'b0);
    send_req(CMD_DECODE, 8'h00, 1'b1);
    send_req(CMD_BUILD, 8'h00, 1'b0);
    send_req(3'd5, 8'hFF, 1'b1);
    send_req(3'd6, 8'h00, 1'b0);
    send_req(3'd7, 8'hA5, 1'b1);
    send_req(CMD_COUNT, 8'hFF, 1'b1);
    send_req(CMD_BUILD, 8'hFF, 1'b1);
    send_req(CMD_ENCODE, 8'hFF, 1'b0);
    send_req(CMD_DECODE, 8'h00, 1'b0);
    send_req(CMD_DECODE, 8'hFF, 1'b1);
    send_req(CMD_ENCODE, 8'h00, 1'b0);
    // Three symbols: a two-level tree, full walks on both branches.
    send_req(CMD_COUNT, 8'h00, 1'b0);
    send_req(CMD_COUNT, 8'h00, 1'b1);
    send_req(CMD_COUNT, 8'h55, 1'b0);
    send_req(CMD_BUILD, 8'h00, 1'b0);
    send_req(CMD_ENCODE, 8'h00, 1'b0);
    send_req(CMD_ENCODE, 8'h55, 1'b1);
    send_req(CMD_ENCODE, 8'hFF, 1'b0);
    send_code(8'h55);
    send_code(8'hFF);
    send_code(8'h00);
    send_req(CMD_CLEAR, 8'hFF, 1'b1);
    send_req(CMD_ENCODE, 8'h00, 1'b0);

    // Random histograms, builds, encodes and decode streams.
    grp = 0;
    while (req_sent < 2000) begin
      grp++;
      if (req_sent > 1700) quiet = 1'b1;
      if ($urandom_range(0, 5) != 0) send_req(CMD_CLEAR, 8'($urandom), 1'($urandom));
      if (grp == 3) k = 256;
      else if ($urandom_range(0, 9) == 0) k = $urandom_range(13, 40);
      else k = $urandom_range(1, 12);
      alph.delete();
      if (k == 256) begin
        for (int i = 0; i < 256; i++) alph.push_back(8'(i));
        alph.shuffle();
      end else
        while (alph.size() < k) begin
          s = 8'($urandom);
          if (!(s inside {alph})) alph.push_back(s);
        end
      if (k == 256)
        foreach (alph[i]) send_req(CMD_COUNT, alph[i], 1'($urandom));
      // Skewed picks give uneven weights and deeper trees.
      repeat ($urandom_range(k, 3 * k + 10)) begin
        send_req(CMD_COUNT, alph[$urandom_range(0, $urandom_range(0, k - 1))],
                 1'($urandom));
        if ($urandom_range(0, 29) == 0)
          send_req(3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom));
      end
      if ($urandom_range(0, 7) == 0) send_req(CMD_ENCODE, alph[0], 1'($urandom));
      send_req(CMD_BUILD, 8'($urandom), 1'($urandom));
      repeat ($urandom_range(5, 25)) begin
        if ($urandom_range(0, 4) != 0) s = alph[$urandom_range(0, k - 1)];
        else s = 8'($urandom);
        send_req(CMD_ENCODE, s, 1'($urandom));
      end
      repeat ($urandom_range(3, 15)) begin
        if ($urandom_range(0, 6) == 0)
          repeat ($urandom_range(1, 4)) send_req(CMD_DECODE, 8'($urandom), 1'($urandom));
        else
          send_code(alph[$urandom_range(0, k - 1)]);
      end
    end
    s_axis_tvalid = 1'b0;
    quiet = 1'b1;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ static_huffman_codec.f @@
src/shc_pkg.sv
src/shc_front.sv
src/shc_fifo.sv
src/shc_back.sv
src/static_huffman_codec.sv
src/shc_checker.sv
dv/tb_static_huffman_codec.sv
